>>> rtl/core/s2a_pkg.sv
// shared types, scan code constants and translation tables for the scan code translator
`timescale 1ns / 1ps

package s2a_pkg;

    localparam logic [7:0] MK_LSHIFT = 8'h2A;
    localparam logic [7:0] MK_RSHIFT = 8'h36;
    localparam logic [7:0] BRK_BIT   = 8'h80;
    localparam logic [7:0] MK_CAPS   = 8'h3A;
    localparam logic [7:0] MK_CTRL   = 8'h1D;
    localparam logic [7:0] MK_ALT    = 8'h38;
    localparam logic [7:0] MK_DEL    = 8'h53;
    localparam logic [7:0] MK_UP     = 8'h48;
    localparam logic [7:0] MK_DOWN   = 8'h50;
    localparam logic [7:0] LAST_CODE = 8'h58;

    localparam logic [7:0] BRK_LSHIFT = MK_LSHIFT | BRK_BIT;
    localparam logic [7:0] BRK_RSHIFT = MK_RSHIFT | BRK_BIT;
    localparam logic [7:0] BRK_CTRL   = MK_CTRL | BRK_BIT;
    localparam logic [7:0] BRK_ALT    = MK_ALT | BRK_BIT;
    localparam logic [7:0] BRK_DEL    = MK_DEL | BRK_BIT;
    localparam logic [7:0] BRK_UP     = MK_UP | BRK_BIT;
    localparam logic [7:0] BRK_DOWN   = MK_DOWN | BRK_BIT;

    typedef enum logic [1:0] {
        SEQ_IDLE     = 2'd0,
        SEQ_CTRL     = 2'd1,
        SEQ_CTRL_ALT = 2'd2
    } s2a_seq_t;

    typedef struct packed {
        logic shift;
        logic caps;
        logic up;
        logic down;
    } s2a_flags_t;

    function automatic logic is_letter(input logic [7:0] c);
        return (c >= 8'h10 && c <= 8'h19) || (c >= 8'h1E && c <= 8'h26) ||
               (c >= 8'h2C && c <= 8'h32);
    endfunction

    // unshifted column, zero for codes not listed (shift, caps, alt and codes beyond the table); ctrl gives 8'h1D
    function automatic logic [7:0] plain_col(input logic [7:0] c);
        logic [7:0] r;
        case (c)
            8'h02: r = "1";
            8'h03: r = "2";
            8'h04: r = "3";
            8'h05: r = "4";
            8'h06: r = "5";
            8'h07: r = "6";
            8'h08: r = "7";
            8'h09: r = "8";
            8'h0A: r = "9";
            8'h0B: r = "0";
            8'h0C: r = "-";
            8'h0D: r = "=";
            8'h0E: r = 8'h08;
            8'h10: r = "q";
            8'h11: r = "w";
            8'h12: r = "e";
            8'h13: r = "r";
            8'h14: r = "t";
            8'h15: r = "y";
            8'h16: r = "u";
            8'h17: r = "i";
            8'h18: r = "o";
            8'h19: r = "p";
            8'h1A: r = "[";
            8'h1B: r = "]";
            8'h1C: r = 8'h0A;
            8'h1D: r = 8'h1D;
            8'h1E: r = "a";
            8'h1F: r = "s";
            8'h20: r = "d";
            8'h21: r = "f";
            8'h22: r = "g";
            8'h23: r = "h";
            8'h24: r = "j";
            8'h25: r = "k";
            8'h26: r = "l";
            8'h27: r = ";";
            8'h28: r = 8'h27;
            8'h29: r = 8'h60;
            8'h2B: r = 8'h5C;
            8'h2C: r = "z";
            8'h2D: r = "x";
            8'h2E: r = "c";
            8'h2F: r = "v";
            8'h30: r = "b";
            8'h31: r = "n";
            8'h32: r = "m";
            8'h33: r = ",";
            8'h34: r = ".";
            8'h35: r = "/";
            8'h37: r = "*";
            8'h39: r = " ";
            8'h55: r = "+";
            8'h56: r = "+";
            default: r = 8'h00;
        endcase
        return r;
    endfunction

    // shifted column, nonzero at the same codes as the unshifted one
    function automatic logic [7:0] shift_col(input logic [7:0] c);
        logic [7:0] r;
        case (c)
            8'h02: r = "!";
            8'h03: r = "@";
            8'h04: r = "#";
            8'h05: r = "$";
            8'h06: r = "%";
            8'h07: r = "^";
            8'h08: r = "&";
            8'h09: r = "*";
            8'h0A: r = "(";
            8'h0B: r = ")";
            8'h0C: r = "_";
            8'h0D: r = "+";
            8'h0E: r = 8'h08;
            8'h10: r = "Q";
            8'h11: r = "W";
            8'h12: r = "E";
            8'h13: r = "R";
            8'h14: r = "T";
            8'h15: r = "Y";
            8'h16: r = "U";
            8'h17: r = "I";
            8'h18: r = "O";
            8'h19: r = "P";
            8'h1A: r = "{";
            8'h1B: r = "}";
            8'h1C: r = 8'h0A;
            8'h1D: r = 8'h1D;
            8'h1E: r = "A";
            8'h1F: r = "S";
            8'h20: r = "D";
            8'h21: r = "F";
            8'h22: r = "G";
            8'h23: r = "H";
            8'h24: r = "J";
            8'h25: r = "K";
            8'h26: r = "L";
            8'h27: r = ":";
            8'h28: r = 8'h22;
            8'h29: r = "~";
            8'h2B: r = "|";
            8'h2C: r = "Z";
            8'h2D: r = "X";
            8'h2E: r = "C";
            8'h2F: r = "V";
            8'h30: r = "B";
            8'h31: r = "N";
            8'h32: r = "M";
            8'h33: r = "<";
            8'h34: r = ">";
            8'h35: r = "?";
            8'h37: r = "*";
            8'h39: r = " ";
            8'h55: r = "*";
            8'h56: r = "*";
            default: r = 8'h00;
        endcase
        return r;
    endfunction

endpackage

>>> rtl/core/s2a_lookup.sv
// character lookup: column selection and table read for one scan code
`timescale 1ns / 1ps

module s2a_lookup (
    input  logic                [7:0] scan_code,
    input  s2a_pkg::s2a_flags_t       flags,
    input  logic                      echo_enable,
    output logic                      char_valid,
    output logic                [7:0] char_code
);

    logic [7:0] plain_byte;
    logic [7:0] shift_byte;
    logic       use_shift;

    always_comb begin
        plain_byte = s2a_pkg::plain_col(scan_code);
        shift_byte = s2a_pkg::shift_col(scan_code);
        // caps lock flips the column for letters only
        if (s2a_pkg::is_letter(scan_code)) begin
            use_shift = flags.shift ^ flags.caps;
        end else begin
            use_shift = flags.shift;
        end
        char_valid = echo_enable && (plain_byte != 8'h00);
        if (char_valid) begin
            char_code = use_shift ? shift_byte : plain_byte;
        end else begin
            char_code = 8'h00;
        end
    end

endmodule

>>> rtl/core/scancode_to_ascii_translator_unit.sv
// top level of the set-1 scan code to character translator
`timescale 1ns / 1ps

// Usage
// s_valid/s_ready/s_scan_code carry one raw set-1 scan code per transaction;
// bit 7 set marks a key release. Every accepted code yields exactly one
// result transaction on m_valid/m_ready with the character (if any), the
// key event and restart flags, and the shift, caps, up and down state after
// that code.
// The result is registered: the result register loads at the edge that accepts
// the code. Throughput is one code per cycle, set by the single result
// register; s_ready is high whenever that register is empty or being taken.
// When the receiver stalls, the result holds and s_ready drops until the
// result is taken.
// cfg_wr_en/cfg_wr_data write echo_enable (reset 1) at any edge with no wait;
// with it at 0 no characters or key events are reported, the state still
// tracks and the restart request is still raised.
// A synchronous reset (aresetn low) clears all key state and the restart
// sequence and empties the result register.

module scancode_to_ascii_translator_unit (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       cfg_wr_en,
    input  logic       cfg_wr_data,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_scan_code,
    output logic       m_valid,
    input  logic       m_ready,
    output logic       m_char_valid,
    output logic [7:0] m_char_code,
    output logic       m_key_event,
    output logic       m_restart_request,
    output logic       m_shift_held,
    output logic       m_caps_on,
    output logic       m_up_held,
    output logic       m_down_held
);

    logic                echo_reg;
    s2a_pkg::s2a_flags_t flags_reg;
    s2a_pkg::s2a_flags_t flags_next;
    s2a_pkg::s2a_seq_t   seq_reg;
    s2a_pkg::s2a_seq_t   seq_next;
    logic                restart_next;
    logic                accept;
    logic                look_valid;
    logic [7:0]          look_code;

    logic       m_valid_reg;
    logic       char_valid_reg;
    logic [7:0] char_code_reg;
    logic       key_event_reg;
    logic       restart_reg;
    logic [3:0] flags_out_reg;

    assign s_ready = !m_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            echo_reg <= 1'b1;
        end else if (cfg_wr_en) begin
            echo_reg <= cfg_wr_data;
        end
    end

    always_comb begin
        flags_next = flags_reg;
        if (s_scan_code == s2a_pkg::MK_LSHIFT || s_scan_code == s2a_pkg::MK_RSHIFT) begin
            flags_next.shift = 1'b1;
        end else if (s_scan_code == s2a_pkg::BRK_LSHIFT ||
                     s_scan_code == s2a_pkg::BRK_RSHIFT) begin
            flags_next.shift = 1'b0;
        end
        if (s_scan_code == s2a_pkg::MK_CAPS) begin
            flags_next.caps = !flags_reg.caps;
        end
        if (s_scan_code == s2a_pkg::MK_UP) begin
            flags_next.up = 1'b1;
        end else if (s_scan_code == s2a_pkg::MK_DOWN) begin
            flags_next.down = 1'b1;
        end else if (s_scan_code == s2a_pkg::BRK_UP) begin
            flags_next.up = 1'b0;
        end else if (s_scan_code == s2a_pkg::BRK_DOWN) begin
            flags_next.down = 1'b0;
        end
    end

    // ctrl, alt, delete make sequence
    always_comb begin
        seq_next     = seq_reg;
        restart_next = 1'b0;
        if (s_scan_code == s2a_pkg::BRK_ALT || s_scan_code == s2a_pkg::BRK_CTRL ||
            s_scan_code == s2a_pkg::BRK_DEL) begin
            seq_next = s2a_pkg::SEQ_IDLE;
        end else if (s_scan_code == s2a_pkg::MK_CTRL) begin
            seq_next = s2a_pkg::SEQ_CTRL;
        end else if (s_scan_code == s2a_pkg::MK_ALT) begin
            seq_next = (seq_reg == s2a_pkg::SEQ_CTRL) ? s2a_pkg::SEQ_CTRL_ALT
                                                      : s2a_pkg::SEQ_IDLE;
        end else if (s_scan_code == s2a_pkg::MK_DEL) begin
            restart_next = (seq_reg == s2a_pkg::SEQ_CTRL_ALT);
            seq_next     = s2a_pkg::SEQ_IDLE;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seq_reg   <= s2a_pkg::SEQ_IDLE;
            flags_reg <= '0;
        end else if (accept) begin
            seq_reg   <= seq_next;
            flags_reg <= flags_next;
        end
    end

    s2a_lookup u_lookup (
        .scan_code   (s_scan_code),
        .flags       (flags_next),
        .echo_enable (echo_reg),
        .char_valid  (look_valid),
        .char_code   (look_code)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (accept) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            char_valid_reg <= look_valid;
            char_code_reg  <= look_code;
            key_event_reg  <= look_valid || ((flags_next.up || flags_next.down) && echo_reg);
            restart_reg    <= restart_next;
            flags_out_reg  <= flags_next;
        end
    end

    assign m_valid           = m_valid_reg;
    assign m_char_valid      = char_valid_reg;
    assign m_char_code       = char_code_reg;
    assign m_key_event       = key_event_reg;
    assign m_restart_request = restart_reg;
    assign m_shift_held      = flags_out_reg[3];
    assign m_caps_on         = flags_out_reg[2];
    assign m_up_held         = flags_out_reg[1];
    assign m_down_held       = flags_out_reg[0];

endmodule

>>> rtl/core/s2a_checker.sv
// port-level checker for the scan code translator, bound to the top level
`timescale 1ns / 1ps

module s2a_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       m_valid,
    input logic       m_ready,
    input logic       m_char_valid,
    input logic [7:0] m_char_code,
    input logic       m_key_event,
    input logic       m_restart_request
);

    // a stalled result transaction holds its payload
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_char_code) &&
        $stable(m_char_valid))
        else $error("result changed while stalled");

    a_no_char_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_char_valid |-> m_char_code == 8'h00)
        else $error("char_code nonzero without char_valid");

    a_char_event: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_char_valid |-> m_key_event)
        else $error("character sent without key event");

    // delete make prints nothing
    a_restart_no_char: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_restart_request |-> !m_char_valid)
        else $error("restart request carried a character");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid right after reset");

endmodule

bind scancode_to_ascii_translator_unit s2a_checker u_s2a_checker (
    .aclk              (aclk),
    .aresetn           (aresetn),
    .m_valid           (m_valid),
    .m_ready           (m_ready),
    .m_char_valid      (m_char_valid),
    .m_char_code       (m_char_code),
    .m_key_event       (m_key_event),
    .m_restart_request (m_restart_request)
);
